[design/masked_transition_moore_fsm_assert.svh]
// Assertion macros used by the state machine RTL.
`ifndef MASKED_TRANSITION_MOORE_FSM_ASSERT_SVH
`define MASKED_TRANSITION_MOORE_FSM_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication: when ante holds, cons must hold.
`define MTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mtm assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define MTM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mtm assertion failed");

`else

`define MTM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MTM_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/mtm_pkg.sv]
// Types and constants of the masked-transition Moore state machine.
package mtm_pkg;

	localparam int STATE_W = 4;
	localparam int ENTRY_W = 3;
	localparam int LINE_W  = 10;
	localparam int CNT_W   = 4;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_OUT   = 2'd1;
	localparam logic [1:0] MODE_ENTRY = 2'd2;
	localparam logic [1:0] MODE_SET   = 2'd3;

	typedef struct packed {
		logic [LINE_W-1:0]  mask;
		logic [LINE_W-1:0]  value;
		logic [STATE_W-1:0] target;
	} entry_t;

endpackage

[design/masked_transition_moore_fsm.sv]
// Top level of the programmable Moore state machine with masked transitions.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------------
//  in       | in_valid / in_ready | mode, state_index, entry_index, mask,
//           |                     | match_values, target_state, output_level,
//           |                     | entry_count, input_bits
//  out      | out_valid/out_ready | present_state, moore_out
//
// A load item (modes 1 to 3) goes from ST_IDLE straight to ST_DONE after accept.
// A tick tests entries in order, at most the state's count, and stops at the first match:
// each entry passes ST_RD for the memory read and ST_CMP for the compare unit.
// One item is in work at a time; in_ready is low from accept until its result
// enters the output register, which holds while out_ready is low.
// Reset clears the current state, all state outputs and all counts; no clearing pass.
module masked_transition_moore_fsm #(
	parameter int STATE_COUNT     = 16,
	parameter int MAX_TRANSITIONS = 8,
	parameter int NUM_INPUT_LINES = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   mode,
	input  logic [mtm_pkg::STATE_W-1:0]  state_index,
	input  logic [mtm_pkg::ENTRY_W-1:0]  entry_index,
	input  logic [mtm_pkg::LINE_W-1:0]   mask,
	input  logic [mtm_pkg::LINE_W-1:0]   match_values,
	input  logic [mtm_pkg::STATE_W-1:0]  target_state,
	input  logic                         output_level,
	input  logic [mtm_pkg::CNT_W-1:0]    entry_count,
	input  logic [mtm_pkg::LINE_W-1:0]   input_bits,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mtm_pkg::STATE_W-1:0]  present_state,
	output logic                         moore_out
);

	`include "masked_transition_moore_fsm_assert.svh"

	// Only states and slots that the index fields can reach get storage.
	localparam int ST_DEPTH = (STATE_COUNT < (1 << mtm_pkg::STATE_W)) ?
		STATE_COUNT : (1 << mtm_pkg::STATE_W);
	localparam int CNT_MAX = (MAX_TRANSITIONS < (1 << mtm_pkg::ENTRY_W)) ?
		MAX_TRANSITIONS : (1 << mtm_pkg::ENTRY_W);
	localparam int SW    = $clog2(ST_DEPTH);
	localparam int KW    = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;
	localparam int CW    = $clog2(CNT_MAX + 1);
	localparam int DEPTH = ST_DEPTH * CNT_MAX;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [mtm_pkg::LINE_W-1:0] LINE_MASK = (NUM_INPUT_LINES >= mtm_pkg::LINE_W) ?
		{mtm_pkg::LINE_W{1'b1}} : mtm_pkg::LINE_W'((64'd1 << NUM_INPUT_LINES) - 64'd1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                   st_q;
	logic [mtm_pkg::STATE_W-1:0]  cur_q;
	logic                         outs_q [ST_DEPTH];
	logic [CW-1:0]                cnts_q [ST_DEPTH];
	logic [KW-1:0]                k_q;
	logic [CW-1:0]                cnt_q;
	logic [mtm_pkg::LINE_W-1:0]   lines_q;
	logic                         out_valid_q;
	logic [mtm_pkg::STATE_W-1:0]  out_state_q;
	logic                         out_moore_q;

	logic                         accept;
	logic                         sidx_ok;
	logic                         eidx_ok;
	logic                         tgt_ok;
	logic [SW-1:0]                sidx;
	logic [SW-1:0]                cur_idx;
	logic [CW-1:0]                cnt_sat;
	logic                         last_entry;
	logic                         done_load;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	mtm_pkg::entry_t              wr_entry;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic                         hit;
	logic [mtm_pkg::STATE_W-1:0]  hit_target;

	assign in_ready   = (st_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign sidx_ok    = (32'(state_index) < ST_DEPTH);
	assign eidx_ok    = (32'(entry_index) < CNT_MAX);
	assign tgt_ok     = (32'(hit_target) < ST_DEPTH);
	assign sidx       = state_index[SW-1:0];
	assign cur_idx    = cur_q[SW-1:0];
	assign cnt_sat    = (32'(entry_count) > CNT_MAX) ? CW'(CNT_MAX) : CW'(entry_count);
	assign last_entry = ((CW'(k_q) + CW'(1)) == cnt_q);
	assign done_load  = (st_q == ST_DONE) && (!out_valid_q || out_ready);

	assign wr_en    = accept && (mode == mtm_pkg::MODE_ENTRY) && sidx_ok && eidx_ok;
	assign wr_addr  = AW'(AW'(sidx) * AW'(CNT_MAX) + AW'(entry_index[KW-1:0]));
	assign wr_entry = '{mask: mask & LINE_MASK, value: match_values & LINE_MASK,
		target: target_state};
	assign rd_en    = (st_q == ST_RD);
	assign rd_addr  = AW'(AW'(cur_idx) * AW'(CNT_MAX) + AW'(k_q));

	mtm_table #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_entry(wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.lines   (lines_q),
		.hit     (hit),
		.target  (hit_target)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			cur_q   <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			lines_q <= '0;
			for (int i = 0; i < ST_DEPTH; i++) begin
				outs_q[i] <= 1'b0;
				cnts_q[i] <= '0;
			end
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_DONE;
						case (mode)
							mtm_pkg::MODE_TICK: begin
								lines_q <= input_bits & LINE_MASK;
								k_q     <= '0;
								cnt_q   <= cnts_q[cur_idx];
								// no entries: keep the state, report at once
								if (cnts_q[cur_idx] != '0) begin
									st_q <= ST_RD;
								end
							end
							mtm_pkg::MODE_OUT: begin
								if (sidx_ok) begin
									outs_q[sidx] <= output_level;
									cnts_q[sidx] <= cnt_sat;
								end
							end
							mtm_pkg::MODE_SET: begin
								if (sidx_ok) begin
									cur_q <= state_index;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD: begin
					st_q <= ST_CMP;
				end
				ST_CMP: begin
					if (hit) begin
						// first match ends the search, even with a target out of range
						if (tgt_ok) begin
							cur_q <= hit_target;
						end
						st_q <= ST_DONE;
					end else if (last_entry) begin
						st_q <= ST_DONE;
					end else begin
						k_q  <= k_q + KW'(1);
						st_q <= ST_RD;
					end
				end
				ST_DONE: begin
					if (done_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_load) begin
			out_state_q <= cur_q;
			out_moore_q <= outs_q[cur_idx];
		end
	end

	assign out_valid     = out_valid_q;
	assign present_state = out_state_q;
	assign moore_out     = out_moore_q;

	`MTM_ASSERT_NXT(a_rd_then_cmp, clk, arst_n, st_q == ST_RD, st_q == ST_CMP)
	`MTM_ASSERT_IMP(a_scan_in_count, clk, arst_n, st_q == ST_RD, CW'(k_q) < cnt_q)
	`MTM_ASSERT_IMP(a_cur_in_range, clk, arst_n, 1'b1, 32'(cur_q) < ST_DEPTH)
	`MTM_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, st_q != ST_IDLE)
	`MTM_ASSERT_NXT(a_done_shows, clk, arst_n, done_load, out_valid_q && (st_q == ST_IDLE))

endmodule

[design/mtm_table.sv]
// Transition entry memory with the masked compare unit on its read port.
module mtm_table #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  mtm_pkg::entry_t              wr_entry,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	input  logic [mtm_pkg::LINE_W-1:0]   lines,
	output logic                         hit,
	output logic [mtm_pkg::STATE_W-1:0]  target
);

	mtm_pkg::entry_t mem [DEPTH];
	mtm_pkg::entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Match bits outside the mask never compare equal, as stored.
	assign hit    = ((lines & rd_q.mask) == rd_q.value);
	assign target = rd_q.target;

endmodule

[dv/tb.sv]
// Testbench for masked_transition_moore_fsm: random load and tick items with a predictor.
`timescale 1ns / 100ps

module tb;

	localparam int N_STATES    = 16;
	localparam int N_SLOTS     = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE      = 40;
	localparam int ITEM_GOAL   = 750;

	typedef logic [mtm_pkg::STATE_W-1:0] state_t;
	typedef logic [mtm_pkg::ENTRY_W-1:0] slot_idx_t;
	typedef logic [mtm_pkg::LINE_W-1:0]  lines_t;
	typedef logic [mtm_pkg::CNT_W-1:0]   count_t;

	typedef struct {
		logic [1:0] mode;
		state_t     state_index;
		slot_idx_t  entry_index;
		lines_t     mask;
		lines_t     match_values;
		state_t     target_state;
		logic       output_level;
		count_t     entry_count;
		lines_t     input_bits;
		int         gap;
		bit         drain;
		state_t     want_state;
		logic       want_out;
	} fsm_item_t;

	typedef struct {
		state_t present_state;
		logic   moore_out;
	} fsm_view_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] mode = mtm_pkg::MODE_TICK;
	state_t     state_index = '0;
	slot_idx_t  entry_index = '0;
	lines_t     mask = '0;
	lines_t     match_values = '0;
	state_t     target_state = '0;
	logic       output_level = 1'b0;
	count_t     entry_count = '0;
	lines_t     input_bits = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	state_t     present_state;
	logic       moore_out;

	masked_transition_moore_fsm uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.state_index(state_index),
		.entry_index(entry_index),
		.mask(mask),
		.match_values(match_values),
		.target_state(target_state),
		.output_level(output_level),
		.entry_count(entry_count),
		.input_bits(input_bits),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.present_state(present_state),
		.moore_out(moore_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow machine, advanced as items are generated
	state_t          fsm_state;
	logic            state_level [N_STATES];
	int              trans_count [N_STATES];
	mtm_pkg::entry_t tr_table [N_STATES*N_SLOTS];
	bit              slot_loaded [N_STATES*N_SLOTS];

	fsm_item_t pending_q [$];
	fsm_view_t expected_views [$];
	fsm_item_t on_wire;
	int        n_items;
	int        results_seen;
	int        fail_count;
	int        hold_cycles;
	int        quiet_cycles;

	function automatic fsm_item_t step_machine(fsm_item_t it);
		int slot;
		bit hit;
		state_t nxt;
		case (it.mode)
			mtm_pkg::MODE_TICK: begin
				nxt = fsm_state;
				hit = 1'b0;
				for (int k = 0; k < N_SLOTS; k++) begin
					slot = int'(fsm_state) * N_SLOTS + k;
					if (!hit && k < trans_count[fsm_state] &&
							(it.input_bits & tr_table[slot].mask) == tr_table[slot].value) begin
						hit = 1'b1;
						nxt = tr_table[slot].target;
					end
				end
				fsm_state = nxt;
			end
			mtm_pkg::MODE_OUT: begin
				state_level[it.state_index] = it.output_level;
				trans_count[it.state_index] = (int'(it.entry_count) > N_SLOTS) ?
					N_SLOTS : int'(it.entry_count);
			end
			mtm_pkg::MODE_ENTRY: begin
				slot = int'(it.state_index) * N_SLOTS + int'(it.entry_index);
				tr_table[slot] = '{it.mask, it.match_values, it.target_state};
				slot_loaded[slot] = 1'b1;
			end
			default: fsm_state = it.state_index;
		endcase
		it.want_state = fsm_state;
		it.want_out = state_level[fsm_state];
		return it;
	endfunction

	function automatic int draw_wait(int count);
		if ((count / 64) % 4 == 2)
			return 0;
		return $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(0, 16);
	endfunction

	// Random filler in every field so that unused fields toggle too
	function automatic fsm_item_t blank_item(logic [1:0] md);
		fsm_item_t it;
		it.mode = md;
		it.state_index = state_t'($urandom_range(0, 15));
		it.entry_index = slot_idx_t'($urandom_range(0, 7));
		it.mask = lines_t'($urandom_range(0, 1023));
		it.match_values = lines_t'($urandom_range(0, 1023));
		it.target_state = state_t'($urandom_range(0, 15));
		it.output_level = 1'($urandom_range(0, 1));
		it.entry_count = count_t'($urandom_range(0, 15));
		it.input_bits = lines_t'($urandom_range(0, 1023));
		return it;
	endfunction

	function automatic lines_t random_mask();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return lines_t'($urandom_range(0, 1023));
			default: return lines_t'($urandom & $urandom & $urandom);
		endcase
	endfunction

	// Pick input bits that satisfy one of the current state's entries most of the time
	function automatic lines_t guided_bits();
		int slot;
		if (trans_count[fsm_state] == 0 || $urandom_range(0, 3) == 0)
			return lines_t'($urandom_range(0, 1023));
		slot = int'(fsm_state) * N_SLOTS + int'($urandom_range(0, trans_count[fsm_state] - 1));
		return (tr_table[slot].value & tr_table[slot].mask) |
			(lines_t'($urandom) & ~tr_table[slot].mask);
	endfunction

	task automatic send(fsm_item_t it);
		it.gap = draw_wait(n_items);
		it.drain = (n_items % 250 == 24);
		pending_q.insert(pending_q.size(), step_machine(it));
		n_items++;
	endtask

	task automatic tick(lines_t bits);
		fsm_item_t it;
		it = blank_item(mtm_pkg::MODE_TICK);
		it.input_bits = bits;
		send(it);
	endtask

	task automatic set_state(int s);
		fsm_item_t it;
		it = blank_item(mtm_pkg::MODE_SET);
		it.state_index = state_t'(s);
		send(it);
	endtask

	task automatic write_entry(int s, int k, lines_t m, lines_t v, state_t t);
		fsm_item_t it;
		it = blank_item(mtm_pkg::MODE_ENTRY);
		it.state_index = state_t'(s);
		it.entry_index = slot_idx_t'(k);
		it.mask = m;
		it.match_values = v;
		it.target_state = t;
		send(it);
	endtask

	task automatic write_random_entry(int s, int k);
		lines_t m;
		lines_t v;
		m = random_mask();
		v = lines_t'($urandom_range(0, 1023));
		// mostly well-formed; the rest carries match bits outside the mask
		if ($urandom_range(0, 99) < 85)
			v = v & m;
		write_entry(s, k, m, v, state_t'($urandom_range(0, 15)));
	endtask

	// Load any entry below the new count that was never written, then the count itself
	task automatic write_state(int s, logic lvl, int cnt);
		fsm_item_t it;
		for (int k = 0; k < N_SLOTS && k < cnt; k++)
			if (!slot_loaded[s * N_SLOTS + k])
				write_random_entry(s, k);
		it = blank_item(mtm_pkg::MODE_OUT);
		it.state_index = state_t'(s);
		it.output_level = lvl;
		it.entry_count = count_t'(cnt);
		send(it);
	endtask

	// Driver
	always @(posedge clk or negedge arst_n) begin
		bit go;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			go = in_valid;
			if (in_valid && in_ready)
				expected_views.insert(expected_views.size(),
					fsm_view_t'{on_wire.want_state, on_wire.want_out});
			if (!in_valid || in_ready) begin
				go = 1'b0;
				if (pending_q.size() != 0 &&
						!(pending_q[0].drain && (in_valid || expected_views.size() != 0))) begin
					if (pending_q[0].gap > 0) begin
						pending_q[0].gap--;
					end else begin
						on_wire = pending_q.pop_front();
						go = 1'b1;
						mode <= on_wire.mode;
						state_index <= on_wire.state_index;
						entry_index <= on_wire.entry_index;
						mask <= on_wire.mask;
						match_values <= on_wire.match_values;
						target_state <= on_wire.target_state;
						output_level <= on_wire.output_level;
						entry_count <= on_wire.entry_count;
						input_bits <= on_wire.input_bits;
					end
				end
			end
			in_valid <= go;
		end
	end

	// Monitor
	always @(posedge clk or negedge arst_n) begin
		fsm_view_t want;
		int stall;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cycles <= 0;
		end else if (out_valid && out_ready) begin
			if (expected_views.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: state %0d out %0b", present_state, moore_out);
			end else begin
				want = expected_views.pop_front();
				if (present_state !== want.present_state || moore_out !== want.moore_out) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result %0d mismatch: state %0d out %0b, expected state %0d out %0b",
							results_seen, present_state, moore_out,
							want.present_state, want.moore_out);
				end
			end
			results_seen++;
			stall = draw_wait(results_seen);
			out_ready <= (stall == 0);
			hold_cycles <= stall;
		end else if (!out_ready) begin
			if (hold_cycles <= 1)
				out_ready <= 1'b1;
			else
				hold_cycles <= hold_cycles - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("masked_transition_moore_fsm test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int sel;
		int s;
		int n;
		fsm_state = '0;
		for (int i = 0; i < N_STATES; i++) begin
			state_level[i] = 1'b0;
			trans_count[i] = 0;
		end
		for (int i = 0; i < N_STATES * N_SLOTS; i++)
			slot_loaded[i] = 1'b0;

		// directed: empty machine, priority order, match bits outside mask, count saturation
		tick('0);
		tick('1);
		write_entry(0, 0, '1, '1, 4'd15);
		write_entry(0, 1, '0, '0, 4'd1);
		write_state(0, 1'b1, 2);
		write_entry(1, 0, 10'h00f, 10'h01f, 4'd2);
		write_entry(1, 1, '0, '0, 4'd0);
		write_state(1, 1'b0, 2);
		tick('1);
		set_state(0);
		tick('0);
		tick(10'h01f);
		for (int k = 0; k < N_SLOTS; k++)
			write_entry(15, k, '1, lines_t'((k << 7) | k), state_t'(15 - k));
		write_state(15, 1'b1, 15);
		set_state(15);
		tick(lines_t'((7 << 7) | 7));
		write_state(8, 1'b1, 0);
		tick('1);

		while (n_items < ITEM_GOAL) begin
			sel = int'($urandom_range(0, 99));
			if (sel < 40) begin
				tick(guided_bits());
			end else if (sel < 55) begin
				write_random_entry(int'($urandom_range(0, 15)), int'($urandom_range(0, 7)));
			end else if (sel < 67) begin
				write_state(int'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
					int'($urandom_range(0, 15)));
			end else if (sel < 75) begin
				set_state(int'($urandom_range(0, 15)));
			end else begin
				// program a whole state, enter it and run it
				s = int'($urandom_range(0, 15));
				n = int'($urandom_range(1, N_SLOTS));
				for (int k = 0; k < n; k++)
					write_random_entry(s, k);
				write_state(s, 1'($urandom_range(0, 1)), n);
				set_state(s);
				repeat ($urandom_range(2, 8))
					tick(guided_bits());
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_q.size() != 0 || in_valid || expected_views.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (expected_views.size() != 0) begin
			fail_count += expected_views.size();
			$display("%0d results never arrived", expected_views.size());
		end
		if (fail_count == 0)
			$display("masked_transition_moore_fsm test passed");
		else
			$display("masked_transition_moore_fsm test failed");
		$finish;
	end

endmodule
